/* rtl/core/pol_pkg.sv */
package pol_pkg;

  localparam int unsigned DEPTH_DEF     = 16;
  localparam int unsigned ELEM_BITS_DEF = 32;

  localparam logic [2:0] KIND_ADD_FRONT = 3'd0;
  localparam logic [2:0] KIND_ADD_REAR  = 3'd1;
  localparam logic [2:0] KIND_REM_FRONT = 3'd2;
  localparam logic [2:0] KIND_REM_REAR  = 3'd3;
  localparam logic [2:0] KIND_INSERT_AT = 3'd4;
  localparam logic [2:0] KIND_REMOVE_AT = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic [2:0]  kind;
    logic [4:0]  position;
    logic [31:0] value;
  } pol_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] removed_value;
    logic [4:0]  entry_count;
  } pol_out_t;

endpackage

/* rtl/core/positional_ordered_list.sv */
// Channel | Dir | Handshake         | Payload
// in      | in  | in_valid/in_stall | pol_in_t  {kind, position, value}
// out     | out | out_valid/out_stall | pol_out_t {status, removed_value, entry_count}
//
// One item at a time; m = elements moved by the operation.
// Status-only items (full, empty, range, unused kind) go straight to the result.
// Add/insert moves m elements up, then writes; remove reads, then moves m down;
// each move reads then writes, as the store has a single read and single write port.
// Reset (rst_n low, synchronous) empties the list; store contents are not cleared.
// The result register frees the input side; out_stall holds it until taken.
module positional_ordered_list #(
  parameter int unsigned DEPTH     = pol_pkg::DEPTH_DEF,
  parameter int unsigned ELEM_BITS = pol_pkg::ELEM_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  pol_pkg::pol_in_t  in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output pol_pkg::pol_out_t out_item
);
  import pol_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [ELEM_BITS-1:0] wr_data;
  logic [AW-1:0]        rd_addr;
  logic [ELEM_BITS-1:0] rd_data;
  logic                 res_valid;
  logic                 res_take;
  pol_out_t             res_item;
  logic                 out_valid_r;
  pol_out_t             out_item_r;

  pol_store #(
    .DEPTH     (DEPTH),
    .ELEM_BITS (ELEM_BITS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  pol_seq #(
    .DEPTH     (DEPTH),
    .ELEM_BITS (ELEM_BITS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res_item  (res_item),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (res_take) begin
        out_valid_r <= 1'b1;
        out_item_r  <= res_item;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

/* rtl/core/pol_store.sv */
module pol_store #(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned ELEM_BITS = 32,
  localparam int unsigned AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  logic [ELEM_BITS-1:0] wr_data,
  input  logic [AW-1:0]        rd_addr,
  output logic [ELEM_BITS-1:0] rd_data
);

  logic [ELEM_BITS-1:0] mem_r [DEPTH];
  logic [ELEM_BITS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/core/pol_seq.sv */
module pol_seq #(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned ELEM_BITS = 32,
  localparam int unsigned AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  pol_pkg::pol_in_t      in_item,
  output logic                  res_valid,
  input  logic                  res_take,
  output pol_pkg::pol_out_t     res_item,
  output logic                  wr_en,
  output logic [AW-1:0]         wr_addr,
  output logic [ELEM_BITS-1:0]  wr_data,
  output logic [AW-1:0]         rd_addr,
  input  logic [ELEM_BITS-1:0]  rd_data
);
  import pol_pkg::*;

  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = ((CW > 5) ? CW : 5) + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_CHK,
    S_INS_WR,
    S_REM_RD,
    S_REM_CAP,
    S_SHF_CHK,
    S_SHF_WR,
    S_FIN
  } state_t;

  state_t               state_r,   state_nxt;
  logic [CW-1:0]        count_r,   count_nxt;
  logic [AW-1:0]        at_r,      at_nxt;
  logic [AW-1:0]        k_r,       k_nxt;
  logic [ELEM_BITS-1:0] val_r,     val_nxt;
  logic [ELEM_BITS-1:0] removed_r, removed_nxt;
  logic [1:0]           status_r,  status_nxt;

  logic            in_fire;
  logic [CMPW-1:0] pos_w;
  logic [CMPW-1:0] cnt_w;
  logic            is_full;

  assign in_stall = (state_r != S_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign pos_w    = CMPW'(in_item.position);
  assign cnt_w    = CMPW'(count_r);
  assign is_full  = (count_r == CW'(DEPTH));

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    at_nxt      = at_r;
    k_nxt       = k_r;
    val_nxt     = val_r;
    removed_nxt = removed_r;
    status_nxt  = status_r;
    wr_en       = 1'b0;
    wr_addr     = k_r;
    wr_data     = rd_data;
    rd_addr     = k_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          val_nxt     = ELEM_BITS'(in_item.value);
          removed_nxt = '0;
          status_nxt  = ST_OK;
          k_nxt       = AW'(count_r);
          state_nxt   = S_FIN;
          case (in_item.kind)
            KIND_ADD_FRONT, KIND_ADD_REAR: begin
              if (is_full) begin
                status_nxt = ST_FULL;
              end else begin
                at_nxt    = (in_item.kind == KIND_ADD_FRONT) ? '0 : AW'(count_r);
                state_nxt = S_INS_CHK;
              end
            end
            KIND_REM_FRONT, KIND_REM_REAR: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                at_nxt    = (in_item.kind == KIND_REM_FRONT) ? '0 : AW'(count_r - CW'(1));
                state_nxt = S_REM_RD;
              end
            end
            KIND_INSERT_AT: begin
              if (pos_w == '0 || pos_w > cnt_w + CMPW'(1)) begin
                status_nxt = ST_RANGE;
              end else if (is_full) begin
                status_nxt = ST_FULL;
              end else begin
                at_nxt    = AW'(pos_w - CMPW'(1));
                state_nxt = S_INS_CHK;
              end
            end
            KIND_REMOVE_AT: begin
              if (pos_w == '0 || pos_w > cnt_w) begin
                status_nxt = ST_RANGE;
              end else begin
                at_nxt    = AW'(pos_w - CMPW'(1));
                state_nxt = S_REM_RD;
              end
            end
            default: begin
              status_nxt = ST_OK;
            end
          endcase
        end
      end
      S_INS_CHK: begin
        if (k_r > at_r) begin
          rd_addr   = k_r - AW'(1);
          state_nxt = S_INS_WR;
        end else begin
          wr_en     = 1'b1;
          wr_addr   = at_r;
          wr_data   = val_r;
          count_nxt = count_r + CW'(1);
          state_nxt = S_FIN;
        end
      end
      S_INS_WR: begin
        wr_en     = 1'b1;
        wr_addr   = k_r;
        wr_data   = rd_data;
        k_nxt     = k_r - AW'(1);
        state_nxt = S_INS_CHK;
      end
      S_REM_RD: begin
        rd_addr   = at_r;
        state_nxt = S_REM_CAP;
      end
      S_REM_CAP: begin
        removed_nxt = rd_data;
        k_nxt       = at_r;
        state_nxt   = S_SHF_CHK;
      end
      S_SHF_CHK: begin
        if ((AW + 1)'(k_r) + (AW + 1)'(1) < (AW + 1)'(count_r)) begin
          rd_addr   = k_r + AW'(1);
          state_nxt = S_SHF_WR;
        end else begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_FIN;
        end
      end
      S_SHF_WR: begin
        wr_en     = 1'b1;
        wr_addr   = k_r;
        wr_data   = rd_data;
        k_nxt     = k_r + AW'(1);
        state_nxt = S_SHF_CHK;
      end
      S_FIN: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      at_r      <= at_nxt;
      k_r       <= k_nxt;
      val_r     <= val_nxt;
      removed_r <= removed_nxt;
      status_r  <= status_nxt;
    end
  end

  assign res_valid              = (state_r == S_FIN);
  assign res_item.status        = status_r;
  assign res_item.removed_value = 32'(removed_r);
  assign res_item.entry_count   = 5'(count_r);

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("element count above depth");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r != S_IDLE)
    else $error("sequencer idle after accepting an item");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && status_r == ST_FULL) |-> is_full)
    else $error("full status with room left");

  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && status_r == ST_EMPTY) |-> (count_r == '0 && removed_r == '0))
    else $error("underflow status on a nonempty list");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_FIN) |-> !wr_en)
    else $error("store written outside an operation");

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import pol_pkg::*;

  localparam int unsigned LIST_DEPTH = DEPTH_DEF;
  localparam logic [2:0]  KIND_SPARE_A = 3'd6;
  localparam logic [2:0]  KIND_SPARE_B = 3'd7;
  localparam int          DRAIN_CYCLES = 2 * LIST_DEPTH + 8;
  localparam int          HOLD_CYCLES  = 150;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  pol_in_t  in_item = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  pol_out_t out_item;

  pol_in_t     pending_ops[$];
  pol_out_t    expected_results[$];
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  logic        hold_go = 1'b0;
  int          hold_left = 0;
  int          ops_queued = 0;
  int          ops_taken = 0;
  int          results_checked = 0;
  int          fail_count = 0;
  int          status_tally[4] = '{0, 0, 0, 0};
  int unsigned gen_len = 0;
  bit          filling = 1'b1;

  logic [31:0] list_mem[LIST_DEPTH];
  int unsigned list_len = 0;

  positional_ordered_list u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
  end

  function automatic void list_insert(int unsigned at, logic [31:0] v);
    for (int unsigned k = list_len; k > at; k--) list_mem[k] = list_mem[k - 1];
    list_mem[at] = v;
    list_len++;
  endfunction

  function automatic logic [31:0] list_take(int unsigned at);
    logic [31:0] v;
    v = list_mem[at];
    for (int unsigned k = at; k + 1 < list_len; k++) list_mem[k] = list_mem[k + 1];
    list_len--;
    return v;
  endfunction

  function automatic pol_out_t apply_list_op(pol_in_t op);
    pol_out_t r;
    r = '0;
    r.status = ST_OK;
    case (op.kind)
      KIND_ADD_FRONT, KIND_ADD_REAR: begin
        if (list_len >= LIST_DEPTH) r.status = ST_FULL;
        else list_insert((op.kind == KIND_ADD_FRONT) ? 0 : list_len, op.value);
      end
      KIND_REM_FRONT, KIND_REM_REAR: begin
        if (list_len == 0) r.status = ST_EMPTY;
        else r.removed_value = list_take((op.kind == KIND_REM_FRONT) ? 0 : list_len - 1);
      end
      KIND_INSERT_AT: begin
        if (op.position < 1 || op.position > list_len + 1) r.status = ST_RANGE;
        else if (list_len >= LIST_DEPTH) r.status = ST_FULL;
        else list_insert(op.position - 1, op.value);
      end
      KIND_REMOVE_AT: begin
        if (op.position < 1 || op.position > list_len) r.status = ST_RANGE;
        else r.removed_value = list_take(op.position - 1);
      end
      default: begin
      end
    endcase
    r.entry_count = 5'(list_len);
    return r;
  endfunction

  task automatic note_failure(input string msg);
    if (fail_count < 50) $display("MISMATCH @%0t: %s", $realtime, msg);
    fail_count++;
  endtask

  // track the fill level so generated positions mostly land inside the list
  task automatic queue_op(input logic [2:0] kind, input logic [4:0] pos,
                          input logic [31:0] val);
    pol_in_t op;
    op.kind = kind;
    op.position = pos;
    op.value = val;
    pending_ops.push_back(op);
    ops_queued++;
    case (kind)
      KIND_ADD_FRONT, KIND_ADD_REAR: if (gen_len < LIST_DEPTH) gen_len++;
      KIND_REM_FRONT, KIND_REM_REAR: if (gen_len > 0) gen_len--;
      KIND_INSERT_AT:
        if (pos >= 1 && pos <= gen_len + 1 && gen_len < LIST_DEPTH) gen_len++;
      KIND_REMOVE_AT: if (pos >= 1 && pos <= gen_len) gen_len--;
      default: begin
      end
    endcase
  endtask

  task automatic queue_random_ops(input int count);
    logic [2:0]  kind;
    logic [4:0]  pos;
    logic [31:0] val;
    int          pick;
    int          i;
    for (i = 0; i < count; i++) begin
      if (gen_len == LIST_DEPTH) filling = 1'b0;
      else if (gen_len == 0) filling = 1'b1;
      else if ($urandom_range(99) < 3) filling = !filling;
      val = $urandom;
      pick = $urandom_range(19);
      if (pick == 0) val = '0;
      else if (pick == 1) val = '1;
      pos = 5'($urandom_range(31));
      pick = $urandom_range(99);
      if (pick < 4) begin
        kind = pick[0] ? KIND_SPARE_B : KIND_SPARE_A;
      end else if (pick < (filling ? 76 : 28)) begin
        case ($urandom_range(2))
          0: kind = KIND_ADD_FRONT;
          1: kind = KIND_ADD_REAR;
          default: begin
            kind = KIND_INSERT_AT;
            if ($urandom_range(9) != 0) pos = 5'($urandom_range(gen_len + 1, 1));
          end
        endcase
      end else begin
        case ($urandom_range(2))
          0: kind = KIND_REM_FRONT;
          1: kind = KIND_REM_REAR;
          default: begin
            kind = KIND_REMOVE_AT;
            if (gen_len != 0 && $urandom_range(9) != 0)
              pos = 5'($urandom_range(gen_len, 1));
          end
        endcase
      end
      queue_op(kind, pos, val);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(apply_list_op(in_item));
        ops_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_item <= pending_ops.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_go) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    pol_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        note_failure($sformatf("result with nothing pending: status %0d count %0d",
                               out_item.status, out_item.entry_count));
      end else begin
        want = expected_results.pop_front();
        status_tally[want.status]++;
        if (out_item.status !== want.status)
          note_failure($sformatf("item %0d status got %0d want %0d",
                                 results_checked, out_item.status, want.status));
        if (out_item.removed_value !== want.removed_value)
          note_failure($sformatf("item %0d removed_value got %h want %h",
                                 results_checked, out_item.removed_value,
                                 want.removed_value));
        if (out_item.entry_count !== want.entry_count)
          note_failure($sformatf("item %0d entry_count got %0d want %0d",
                                 results_checked, out_item.entry_count,
                                 want.entry_count));
      end
      results_checked++;
    end
  end

  initial begin
    int k;
    wait (rst_n);
    @(posedge clk);
    send_idle_pct <= 8;
    recv_idle_pct <= 59;

    queue_op(KIND_REM_FRONT, 5'd0, 32'h0);
    queue_op(KIND_REM_REAR, 5'd31, 32'h0);
    queue_op(KIND_REMOVE_AT, 5'd1, 32'h0);
    queue_op(KIND_INSERT_AT, 5'd0, 32'h1111_1111);
    queue_op(KIND_INSERT_AT, 5'd2, 32'h2222_2222);
    queue_op(KIND_INSERT_AT, 5'd1, 32'h0000_0000);
    queue_op(KIND_ADD_FRONT, 5'd0, 32'hFFFF_FFFF);
    queue_op(KIND_ADD_REAR, 5'd0, 32'h1234_5678);
    queue_op(KIND_INSERT_AT, 5'd2, 32'hA5A5_A5A5);
    queue_op(KIND_REMOVE_AT, 5'd0, 32'h0);
    queue_op(KIND_REMOVE_AT, 5'd5, 32'h0);
    queue_op(KIND_REMOVE_AT, 5'd3, 32'h0);
    queue_op(KIND_SPARE_A, 5'd31, 32'hFFFF_FFFF);
    queue_op(KIND_SPARE_B, 5'd16, 32'h5A5A_5A5A);
    for (k = 0; gen_len < LIST_DEPTH; k++)
      queue_op(k[0] ? KIND_ADD_REAR : KIND_INSERT_AT, 5'(gen_len + 1), $urandom);
    queue_op(KIND_ADD_FRONT, 5'd0, 32'hDEAD_0001);
    queue_op(KIND_ADD_REAR, 5'd0, 32'hDEAD_0002);
    queue_op(KIND_INSERT_AT, 5'd17, 32'hDEAD_0003);
    queue_op(KIND_INSERT_AT, 5'd18, 32'hDEAD_0004);
    queue_op(KIND_REMOVE_AT, 5'd17, 32'h0);
    queue_op(KIND_REMOVE_AT, 5'd16, 32'h0);
    queue_op(KIND_REM_FRONT, 5'd0, 32'h0);
    queue_op(KIND_REM_REAR, 5'd0, 32'h0);
    queue_random_ops(120);
    while (pending_ops.size() != 0) @(posedge clk);

    send_idle_pct <= 59;
    recv_idle_pct <= 8;
    queue_random_ops(130);
    while (pending_ops.size() != 0) @(posedge clk);

    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    queue_random_ops(140);
    @(posedge clk);
    hold_go <= 1'b1;
    @(posedge clk);
    hold_go <= 1'b0;

    while (ops_taken != ops_queued) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0)
      note_failure($sformatf("%0d results never arrived", expected_results.size()));

    $display("Ran %0d list operations under three idle mixes and one long output hold.",
             ops_taken);
    $display("Checked %0d results: ok %0d, empty %0d, range %0d, full %0d.",
             results_checked, status_tally[0], status_tally[1], status_tally[2],
             status_tally[3]);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Timeout with %0d of %0d operations taken", ops_taken, ops_queued);
    $display("Some tests failed");
    $finish;
  end

endmodule
